@@ rtl/core/mbs_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the block-sum unit.
package mbs_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_VALUE_BITS  = 8;

    // Fixed field widths
    localparam int SUM_W        = 20;
    localparam int IDX_W        = 6;
    localparam int ROWS_CFG_W   = 7;
    localparam int COLS_CFG_W   = 7;
    localparam int RADIUS_W     = 6;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 7;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS       = 2'd2;

    // Input op codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic start;     // latch word, resolve position
        logic div_step;  // one quotient bit of position / columns
        logic load_wr;   // write row prefix
        logic bounds;    // register window edges, clear sum
        logic row_rd;    // read both prefixes of one window row
        logic out_load;  // move sum into output register
    } t_cmd;

    typedef struct packed {
        logic op;        // op of the word in progress
        logic loaded;    // full matrix present
        logic last_row;  // current window row is the bottom one
        logic out_free;  // output register can take a result
    } t_status;

endpackage

@@ rtl/core/mbs_ctrl.sv @@
// Sequencing state machine for the block-sum unit.
module mbs_ctrl #(
    parameter int MAX_ROWS = mbs_pkg::DEF_MAX_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_op,
    output logic             o_in_ready,
    input  mbs_pkg::t_status i_status,
    output mbs_pkg::t_cmd    o_cmd
);
    import mbs_pkg::*;

    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNTW = (RW > 1) ? $clog2(RW) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_LRD  = 3'd2;
    localparam logic [2:0] S_LWR  = 3'd3;
    localparam logic [2:0] S_BND  = 3'd4;
    localparam logic [2:0] S_ROW  = 3'd5;
    localparam logic [2:0] S_TAIL = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                // a drain word before the matrix is complete is absorbed here
                if (i_in_valid && (i_op == OP_LOAD || i_status.loaded)) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(RW - 1)) begin
                    n_state = (i_status.op == OP_LOAD) ? S_LRD : S_BND;
                end
            end
            S_LRD: n_state = S_LWR;
            S_LWR: begin
                o_cmd.load_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_BND: begin
                o_cmd.bounds = 1'b1;
                n_state      = S_ROW;
            end
            S_ROW: begin
                o_cmd.row_rd = 1'b1;
                if (i_status.last_row) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: n_state = S_FIN;
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ rtl/core/mbs_datapath.sv @@
// Configuration, prefix store, position divider, window accumulator and output register.
module mbs_datapath #(
    parameter int MAX_ROWS    = mbs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = mbs_pkg::DEF_MAX_COLUMNS,
    parameter int VALUE_BITS  = mbs_pkg::DEF_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [mbs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_op,
    input  logic [VALUE_BITS-1:0]           i_value,
    input  mbs_pkg::t_cmd                   i_cmd,
    output mbs_pkg::t_status                o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mbs_pkg::SUM_W-1:0]       o_block_sum,
    output logic [mbs_pkg::IDX_W-1:0]       o_row_index,
    output logic [mbs_pkg::IDX_W-1:0]       o_column_index,
    output logic                            o_last
);
    import mbs_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int NCW   = $clog2(MAX_COLUMNS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PSW   = $clog2(DEPTH + 1);
    localparam int TW    = PSW + RW;
    localparam int PW    = VALUE_BITS + ((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 0);
    localparam int MW    = (RW > CW) ? RW : CW;
    localparam int EW    = ((MW > RADIUS_W) ? MW : RADIUS_W) + 1;

    // configuration
    logic [ROWS_CFG_W-1:0] r_cfg_rows;
    logic [COLS_CFG_W-1:0] r_cfg_cols;
    logic [RADIUS_W-1:0]   r_cfg_radius;
    logic [NRW-1:0]        rows_used;
    logic [NCW-1:0]        cols_used;
    logic [PSW-1:0]        total;

    // control state
    logic                  r_loaded;
    logic [PSW-1:0]        r_load_pos;
    logic [PSW-1:0]        r_drain_pos;
    logic                  r_rd_vld;
    logic                  r_out_valid;

    // item payload
    logic                  r_op;
    logic [VALUE_BITS-1:0] r_value;
    logic [PSW-1:0]        r_pos;
    logic [PSW-1:0]        r_rem;
    logic [RW-1:0]         r_quot;
    logic [TW-1:0]         r_trial;
    logic [RW-1:0]         r_k;
    logic [RW-1:0]         r_rhi;
    logic [CW-1:0]         r_clo;
    logic [CW-1:0]         r_chi;
    logic [SUM_W-1:0]      r_sum;
    logic [PW-1:0]         r_rd_a;
    logic [PW-1:0]         r_rd_b;
    logic [PW-1:0]         r_mem [DEPTH];
    logic [SUM_W-1:0]      r_out_sum;
    logic [IDX_W-1:0]      r_out_row;
    logic [IDX_W-1:0]      r_out_col;
    logic                  r_out_last;

    logic [PSW-1:0]        pos_src, pos_eff, pos_next;
    logic                  q_bit;
    logic [CW-1:0]         col_cur;
    logic [EW-1:0]         r_e, c_e, rad_e, rlo_e, rhi_e, clo_e, chi_e, rtop_e, ctop_e;
    logic [AW-1:0]         addr_a, addr_b, addr_wr;
    logic [PW-1:0]         load_prefix;
    logic [SUM_W-1:0]      row_diff;

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
        return AW'(row) * AW'(MAX_COLUMNS) + AW'(col);
    endfunction

    // size registers saturate into 1..MAX
    always_comb begin
        if (r_cfg_rows == '0) begin
            rows_used = NRW'(1);
        end else if (int'(r_cfg_rows) > MAX_ROWS) begin
            rows_used = NRW'(MAX_ROWS);
        end else begin
            rows_used = NRW'(r_cfg_rows);
        end
        if (r_cfg_cols == '0) begin
            cols_used = NCW'(1);
        end else if (int'(r_cfg_cols) > MAX_COLUMNS) begin
            cols_used = NCW'(MAX_COLUMNS);
        end else begin
            cols_used = NCW'(r_cfg_cols);
        end
    end

    assign total = PSW'(rows_used) * PSW'(cols_used);

    // a load after a full matrix restarts at 0; stale positions wrap to 0
    assign pos_src  = (i_op == OP_LOAD) ? (r_loaded ? '0 : r_load_pos) : r_drain_pos;
    assign pos_eff  = (pos_src >= total) ? '0 : pos_src;
    assign pos_next = r_pos + PSW'(1);
    assign q_bit    = (TW'(r_rem) >= r_trial);
    assign col_cur  = CW'(r_rem);

    // window edges, clipped at the matrix border
    always_comb begin
        r_e    = EW'(r_quot);
        c_e    = EW'(col_cur);
        rad_e  = EW'(r_cfg_radius);
        rtop_e = EW'(rows_used) - EW'(1);
        ctop_e = EW'(cols_used) - EW'(1);
        rlo_e  = (r_e > rad_e) ? r_e - rad_e : '0;
        clo_e  = (c_e > rad_e) ? c_e - rad_e : '0;
        rhi_e  = (r_e + rad_e < rtop_e) ? r_e + rad_e : rtop_e;
        chi_e  = (c_e + rad_e < ctop_e) ? c_e + rad_e : ctop_e;
    end

    assign addr_a  = (r_op == OP_LOAD) ? addr_of(r_quot, col_cur - CW'(1))
                                       : addr_of(r_k, r_chi);
    assign addr_b  = addr_of(r_k, r_clo - CW'(1));
    assign addr_wr = addr_of(r_quot, col_cur);

    assign load_prefix = PW'(r_value) + ((col_cur != '0) ? r_rd_a : '0);
    // difference taken at sum width so stale prefixes wrap the same way as the sum
    assign row_diff    = SUM_W'(r_rd_a) - ((r_clo != '0) ? SUM_W'(r_rd_b) : '0);

    // prefix store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem[addr_wr] <= load_prefix;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows   <= ROWS_CFG_W'(1);
            r_cfg_cols   <= COLS_CFG_W'(1);
            r_cfg_radius <= '0;
            r_loaded     <= 1'b0;
            r_load_pos   <= '0;
            r_drain_pos  <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_ROW_COUNT:    r_cfg_rows   <= i_cfg_wdata[ROWS_CFG_W-1:0];
                    CFG_COLUMN_COUNT: r_cfg_cols   <= i_cfg_wdata[COLS_CFG_W-1:0];
                    CFG_RADIUS:       r_cfg_radius <= i_cfg_wdata[RADIUS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.start && i_op == OP_LOAD && r_loaded) begin
                r_loaded    <= 1'b0;
                r_load_pos  <= '0;
                r_drain_pos <= '0;
            end
            if (i_cmd.load_wr) begin
                r_load_pos <= pos_next;
                if (pos_next >= total) begin
                    r_loaded    <= 1'b1;
                    r_drain_pos <= '0;
                end
            end
            if (i_cmd.out_load) begin
                r_drain_pos <= (pos_next >= total) ? '0 : pos_next;
            end
            r_rd_vld <= i_cmd.row_rd;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_pos   <= pos_eff;
            r_rem   <= pos_eff;
            r_quot  <= '0;
            r_trial <= TW'(cols_used) << (RW - 1);
        end
        // restoring division, one quotient bit per step: row and column
        if (i_cmd.div_step) begin
            if (q_bit) begin
                r_rem <= PSW'(TW'(r_rem) - r_trial);
            end
            r_quot  <= RW'({r_quot, q_bit});
            r_trial <= r_trial >> 1;
        end
        if (i_cmd.bounds) begin
            r_k   <= RW'(rlo_e);
            r_rhi <= RW'(rhi_e);
            r_clo <= CW'(clo_e);
            r_chi <= CW'(chi_e);
            r_sum <= '0;
        end else begin
            if (i_cmd.row_rd) begin
                r_k <= r_k + RW'(1);
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + row_diff;
            end
        end
        if (i_cmd.out_load) begin
            r_out_sum  <= r_sum;
            r_out_row  <= IDX_W'(r_quot);
            r_out_col  <= IDX_W'(col_cur);
            r_out_last <= (r_pos == total - PSW'(1));
        end
    end

    assign o_status.op       = r_op;
    assign o_status.loaded   = r_loaded;
    assign o_status.last_row = (r_k == r_rhi);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_block_sum    = r_out_sum;
    assign o_row_index    = r_out_row;
    assign o_column_index = r_out_col;
    assign o_last         = r_out_last;

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken word");

    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bounds |-> (EW'(r_quot) < EW'(rows_used)) && (r_rem < PSW'(cols_used)))
        else $error("divided position outside the matrix");

    a_row_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.row_rd |-> (r_k <= r_rhi))
        else $error("window row past the bottom edge");

    a_load_while_filling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_wr |-> !r_loaded && (r_pos < total))
        else $error("prefix written outside a load");

endmodule

@@ rtl/core/matrix_block_sum_unit.sv @@
// Top level of the clamped-window 2D block-sum unit.
//
// Load words (op 0) fill a row_count x column_count matrix in row-major order,
// each element kept as a row prefix sum; drain words (op 1) then return the sum
// over the window of +/- radius rows and columns around successive positions,
// clipped at the edges, with last set on the final position. A load word passes
// the bit-serial divider that splits the linear position into row and column,
// then a prefix read and a prefix write. A drain word passes the same divider,
// then sums the window rows: the prefix store yields both prefixes of one window
// row per cycle through its two read ports. A drain word that arrives before the
// matrix is complete is taken and gives no result. The finished sum sits in an
// output register, so a waiting result does not stop the next word from being
// taken. The store needs no clearing after reset.
module matrix_block_sum_unit #(
    parameter int MAX_ROWS    = mbs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = mbs_pkg::DEF_MAX_COLUMNS,
    parameter int VALUE_BITS  = mbs_pkg::DEF_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [mbs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_op,
    input  logic [VALUE_BITS-1:0]           i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mbs_pkg::SUM_W-1:0]       o_block_sum,
    output logic [mbs_pkg::IDX_W-1:0]       o_row_index,
    output logic [mbs_pkg::IDX_W-1:0]       o_column_index,
    output logic                            o_last
);
    import mbs_pkg::*;

    t_cmd    cmd;
    t_status status;

    mbs_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mbs_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_block_sum    (o_block_sum),
        .o_row_index    (o_row_index),
        .o_column_index (o_column_index),
        .o_last         (o_last)
    );

endmodule

@@ test/matrix_block_sum_unit_test.sv @@
// Self-checking testbench for matrix_block_sum_unit: directed table, then random load/drain traffic.
module matrix_block_sum_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbs_pkg::*;

    localparam int ROWS_MAX    = DEF_MAX_ROWS;
    localparam int COLS_MAX    = DEF_MAX_COLUMNS;
    localparam int VBITS       = DEF_VALUE_BITS;
    localparam int SETTLE      = 100;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_box_sum;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} t_check;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
        logic                  op;
        logic [VBITS-1:0]      value;
        t_check                chk;
        t_box_sum              want;
    } t_plan_step;

    typedef struct {
        int rows;
        int cols;
        int rad;
        int send_pct;
        int stall_pct;
        int words;
        bit pause;
    } t_phase;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_wr_en    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata    = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic                  i_op           = OP_LOAD;
    logic [VBITS-1:0]      i_value        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [SUM_W-1:0]      o_block_sum;
    logic [IDX_W-1:0]      o_row_index;
    logic [IDX_W-1:0]      o_column_index;
    logic                  o_last;

    matrix_block_sum_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_block_sum    (o_block_sum),
        .o_row_index    (o_row_index),
        .o_column_index (o_column_index),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // shadow of the block: registers, row prefix store, positions
    logic [ROWS_CFG_W-1:0] shadow_rows   = 7'd1;
    logic [COLS_CFG_W-1:0] shadow_cols   = 7'd1;
    logic [RADIUS_W-1:0]   shadow_radius = '0;
    logic [13:0]           prefix_image [ROWS_MAX*COLS_MAX];
    bit                    prefix_known [ROWS_MAX*COLS_MAX];
    int unsigned           load_pos      = 0;
    int unsigned           drain_pos     = 0;
    bit                    matrix_full   = 1'b0;

    t_box_sum    expected_sums [$];
    int          mismatches  = 0;
    int          send_pct    = 0;
    int          stall_pct   = 0;
    int unsigned cycle_count = 0;

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned top);
        if (v < 1) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int unsigned slot(input int unsigned r, input int unsigned c);
        return r * COLS_MAX + c;
    endfunction

    function automatic void window_of(input int unsigned pos,
                                      output int unsigned r, output int unsigned c,
                                      output int unsigned rlo, output int unsigned rhi,
                                      output int unsigned clo, output int unsigned chi);
        int unsigned rows;
        int unsigned cols;
        rows = clamp_size(shadow_rows, ROWS_MAX);
        cols = clamp_size(shadow_cols, COLS_MAX);
        r    = pos / cols;
        c    = pos % cols;
        rlo  = (r > shadow_radius) ? r - shadow_radius : 0;
        rhi  = (r + shadow_radius < rows - 1) ? r + shadow_radius : rows - 1;
        clo  = (c > shadow_radius) ? c - shadow_radius : 0;
        chi  = (c + shadow_radius < cols - 1) ? c + shadow_radius : cols - 1;
    endfunction

    // true when the next drain word touches only prefixes written since reset
    function automatic bit drain_reads_known();
        int unsigned total;
        int unsigned pos;
        int unsigned r, c, rlo, rhi, clo, chi;
        if (!matrix_full) return 1'b1;
        total = clamp_size(shadow_rows, ROWS_MAX) * clamp_size(shadow_cols, COLS_MAX);
        pos   = (drain_pos >= total) ? 0 : drain_pos;
        window_of(pos, r, c, rlo, rhi, clo, chi);
        for (int unsigned k = rlo; k <= rhi; k++) begin
            if (!prefix_known[slot(k, chi)]) return 1'b0;
            if (clo > 0 && !prefix_known[slot(k, clo - 1)]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_block_sum(input logic op, input logic [VBITS-1:0] val,
                                     output bit produced, output t_box_sum res);
        int unsigned cols;
        int unsigned total;
        int unsigned r, c, rlo, rhi, clo, chi;
        int unsigned acc;
        int unsigned right;
        int unsigned left;
        cols     = clamp_size(shadow_cols, COLS_MAX);
        total    = clamp_size(shadow_rows, ROWS_MAX) * cols;
        produced = 1'b0;
        res      = '0;
        if (op == OP_LOAD) begin
            if (matrix_full) begin
                matrix_full = 1'b0;
                load_pos    = 0;
                drain_pos   = 0;
            end
            if (load_pos >= total) load_pos = 0;
            r   = load_pos / cols;
            c   = load_pos % cols;
            acc = val;
            if (c > 0) acc += prefix_image[slot(r, c - 1)];
            prefix_image[slot(r, c)] = acc[13:0];
            prefix_known[slot(r, c)] = 1'b1;
            load_pos++;
            if (load_pos >= total) begin
                matrix_full = 1'b1;
                drain_pos   = 0;
            end
        end else if (matrix_full) begin
            if (drain_pos >= total) drain_pos = 0;
            window_of(drain_pos, r, c, rlo, rhi, clo, chi);
            acc = 0;
            for (int unsigned k = rlo; k <= rhi; k++) begin
                right = prefix_image[slot(k, chi)];
                left  = (clo > 0) ? prefix_image[slot(k, clo - 1)] : 0;
                acc  += right - left;
            end
            res.sum  = acc[SUM_W-1:0];
            res.row  = r[IDX_W-1:0];
            res.col  = c[IDX_W-1:0];
            res.last = (drain_pos == total - 1);
            produced = 1'b1;
            drain_pos++;
            if (drain_pos >= total) drain_pos = 0;
        end
    endtask

    function automatic int gap_len(input int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct && n < 50) n++;
        return n;
    endfunction

    function automatic logic [VBITS-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return VBITS'($urandom_range((1 << VBITS) - 1));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (addr)
            CFG_ROW_COUNT:    shadow_rows   = data;
            CFG_COLUMN_COUNT: shadow_cols   = data;
            CFG_RADIUS:       shadow_radius = data[RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_word(input logic op, input logic [VBITS-1:0] val,
                             input t_check chk, input t_box_sum want);
        int       gap;
        bit       produced;
        t_box_sum got;
        gap = gap_len(send_pct);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        predict_block_sum(op, val, produced, got);
        if (chk == CHK_TYPED) expected_sums.push_back(want);
        else if (chk == CHK_MODEL && produced) expected_sums.push_back(got);
    endtask

    // drop valid, wait for every pending sum, then let a drain word in flight finish
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_word();
        logic op;
        if (!matrix_full) begin
            op = ($urandom_range(99) < 6) ? OP_DRAIN : OP_LOAD;
        end else begin
            op = ($urandom_range(99) < 4) ? OP_LOAD : OP_DRAIN;
            if (op == OP_DRAIN && !drain_reads_known()) op = OP_LOAD;
        end
        send_word(op, pick_value(), CHK_MODEL, '0);
    endtask

    task automatic set_shape(input int rows, input int cols, input int rad);
        int unsigned new_total;
        new_total = clamp_size(rows, ROWS_MAX) * clamp_size(cols, COLS_MAX);
        // a partial load that would resume part way into the new shape is finished first
        if (!matrix_full && load_pos != 0 && load_pos < new_total) begin
            while (!matrix_full) send_word(OP_LOAD, pick_value(), CHK_MODEL, '0);
        end
        settle_block();
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows));
        write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'(cols));
        write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
    endtask

    function automatic t_plan_step reg_step(input logic [CFG_ADDR_W-1:0] addr,
                                            input logic [CFG_DATA_W-1:0] data);
        t_plan_step s;
        s.is_cfg = 1'b1;
        s.addr   = addr;
        s.data   = data;
        s.op     = OP_LOAD;
        s.value  = '0;
        s.chk    = CHK_NONE;
        s.want   = '0;
        return s;
    endfunction

    function automatic t_plan_step word_step(input logic op, input logic [VBITS-1:0] val,
                                             input t_check chk, input int sum,
                                             input int row, input int col, input bit last);
        t_plan_step s;
        s.is_cfg    = 1'b0;
        s.addr      = '0;
        s.data      = '0;
        s.op        = op;
        s.value     = val;
        s.chk       = chk;
        s.want.sum  = SUM_W'(sum);
        s.want.row  = IDX_W'(row);
        s.want.col  = IDX_W'(col);
        s.want.last = last;
        return s;
    endfunction

    function automatic t_phase make_phase(input int rows, input int cols, input int rad,
                                          input int sp, input int rp, input int words,
                                          input bit pause);
        t_phase ph;
        ph.rows      = rows;
        ph.cols      = cols;
        ph.rad       = rad;
        ph.send_pct  = sp;
        ph.stall_pct = rp;
        ph.words     = words;
        ph.pause     = pause;
        return ph;
    endfunction

    always @(negedge i_clk) i_out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin : check_results
        t_box_sum seen;
        t_box_sum want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.sum  = o_block_sum;
            seen.row  = o_row_index;
            seen.col  = o_column_index;
            seen.last = o_last;
            if (expected_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sum %0d at (%0d,%0d) last %0b",
                             seen.sum, seen.row, seen.col, seen.last);
            end else begin
                want = expected_sums.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"sum mismatch: exp %0d (%0d,%0d) last %0b, ",
                                  "got %0d (%0d,%0d) last %0b"},
                                 want.sum, want.row, want.col, want.last,
                                 seen.sum, seen.row, seen.col, seen.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        t_plan_step plan [$];
        t_phase     phases [$];
        int         mix;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 1x1, radius 0 after reset
        plan.push_back(word_step(OP_DRAIN, 8'h5A, CHK_NONE, 0, 0, 0, 0));  // nothing loaded yet
        plan.push_back(word_step(OP_LOAD, 8'hFF, CHK_NONE, 0, 0, 0, 0));
        plan.push_back(word_step(OP_DRAIN, 8'h00, CHK_TYPED, 255, 0, 0, 1));
        plan.push_back(word_step(OP_DRAIN, 8'hFF, CHK_TYPED, 255, 0, 0, 1)); // wraps to 0
        plan.push_back(word_step(OP_LOAD, 8'h00, CHK_NONE, 0, 0, 0, 0));    // new matrix
        plan.push_back(word_step(OP_DRAIN, 8'h00, CHK_TYPED, 0, 0, 0, 1));
        plan.push_back(reg_step(CFG_ROW_COUNT, 7'd2));
        plan.push_back(reg_step(CFG_COLUMN_COUNT, 7'd3));
        plan.push_back(reg_step(CFG_RADIUS, 7'd0));
        plan.push_back(word_step(OP_LOAD, 8'hFF, CHK_NONE, 0, 0, 0, 0));
        plan.push_back(word_step(OP_LOAD, 8'h00, CHK_NONE, 0, 0, 0, 0));
        plan.push_back(word_step(OP_LOAD, 8'h80, CHK_NONE, 0, 0, 0, 0));
        plan.push_back(word_step(OP_DRAIN, 8'h00, CHK_NONE, 0, 0, 0, 0));   // load incomplete
        plan.push_back(word_step(OP_LOAD, 8'h01, CHK_NONE, 0, 0, 0, 0));
        plan.push_back(word_step(OP_LOAD, 8'h7F, CHK_NONE, 0, 0, 0, 0));
        plan.push_back(word_step(OP_LOAD, 8'hFF, CHK_NONE, 0, 0, 0, 0));
        plan.push_back(word_step(OP_DRAIN, 8'h00, CHK_TYPED, 255, 0, 0, 0));
        plan.push_back(word_step(OP_DRAIN, 8'h00, CHK_TYPED, 0, 0, 1, 0));
        plan.push_back(reg_step(CFG_RADIUS, 7'd1));
        plan.push_back(word_step(OP_DRAIN, 8'h00, CHK_MODEL, 0, 0, 0, 0));
        plan.push_back(word_step(OP_DRAIN, 8'h00, CHK_MODEL, 0, 0, 0, 0));
        plan.push_back(reg_step(CFG_RADIUS, 7'd63));
        plan.push_back(word_step(OP_DRAIN, 8'h00, CHK_TYPED, 766, 1, 1, 0));
        plan.push_back(word_step(OP_DRAIN, 8'h00, CHK_TYPED, 766, 1, 2, 1));
        plan.push_back(word_step(OP_DRAIN, 8'h00, CHK_TYPED, 766, 0, 0, 0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle_block();
                write_reg(plan[i].addr, plan[i].data);
            end else begin
                send_word(plan[i].op, plan[i].value, plan[i].chk, plan[i].want);
            end
        end
        settle_block();
        write_reg(CFG_UNUSED, '1);

        // 4x8 stops part way; the 2x3 shape after it forces the load position to wrap
        phases.push_back(make_phase(4, 8, 1, 0, 0, 20, 0));
        phases.push_back(make_phase(2, 3, 0, 55, 0, 60, 0));
        phases.push_back(make_phase(8, 8, 2, 0, 55, 150, 0));
        phases.push_back(make_phase(5, 7, 1, 13, 13, 150, 1));
        phases.push_back(make_phase(0, 127, 3, 0, 0, 150, 0));
        phases.push_back(make_phase(127, 1, 63, 55, 0, 150, 0));
        phases.push_back(make_phase(64, 4, 63, 0, 55, 320, 0));
        phases.push_back(make_phase(4, 64, 5, 13, 13, 320, 0));
        phases.push_back(make_phase(3, 3, 0, 0, 0, 100, 0));   // shrink: drain position wraps
        repeat (3) begin
            mix = $urandom_range(3);
            phases.push_back(make_phase($urandom_range(1, 10), $urandom_range(1, 10),
                                        $urandom_range(0, 12),
                                        (mix == 1) ? 55 : (mix == 3) ? 13 : 0,
                                        (mix == 2) ? 55 : (mix == 3) ? 13 : 0,
                                        80, 0));
        end

        foreach (phases[p]) begin
            set_shape(phases[p].rows, phases[p].cols, phases[p].rad);
            send_pct  = phases[p].send_pct;
            stall_pct = phases[p].stall_pct;
            for (int w = 0; w < phases[p].words; w++) begin
                if (phases[p].pause && w == phases[p].words / 2) settle_block();
                random_word();
            end
        end

        settle_block();
        if (mismatches == 0 && expected_sums.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
